// ===== rtl/smooth_vertex_normal_builder_assert.svh =====
// assertion macros used by the normal builder top level
`ifndef SMOOTH_VERTEX_NORMAL_BUILDER_ASSERT_SVH
`define SMOOTH_VERTEX_NORMAL_BUILDER_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define SVNB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svnb assertion failed");

// next-cycle implication, quiet while reset is high
`define SVNB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svnb assertion failed");

`endif

// ===== rtl/svnb_pkg.sv =====
// shared types and constants of the smooth vertex normal builder
package svnb_pkg;

  // item function codes
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_TRI  = 2'd1;
  localparam logic [1:0] FUNC_FIN  = 2'd2;

  localparam int ACC_W   = 48;  // accumulator component width
  localparam int NORM_W  = 30;  // magnitude width after normalising
  localparam int SQ_W    = 62;  // sum of squares width
  localparam int ROOT_W  = 31;  // square root width
  localparam int NUM_W   = 45;  // divider numerator width
  localparam int QUO_W   = 15;  // divider quotient width
  localparam int CORNER_W = 6;
  localparam int OUT_W   = 16;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       tri_cap;
    logic       fin_init;
    logic       pos_rd;
    logic       acc_rd;
    logic       acc_wr;
    logic       use_vidx;
    logic [1:0] sel;
    logic       edge_en;
    logic       mul_en;
    logic       mul_sq;
    logic [2:0] mul_sel;
    logic       abs_en;
    logic       max_en;
    logic       norm_step;
    logic       sq_clr;
    logic       sqrt_start;
    logic       div_start;
    logic       next_vertex;
  } svnb_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic tri_ok;
    logic store_empty;
    logic mag_zero;
    logic norm_ok;
    logic sqrt_done;
    logic div_done;
    logic last_vertex;
  } svnb_stat_t;

endpackage

// ===== rtl/svnb_isqrt.sv =====
// iterative floor square root, one result bit per cycle
module svnb_isqrt import svnb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic [SQ_W-1:0] x;
  logic [SQ_W-1:0] r;
  logic [SQ_W-1:0] b;
  logic [4:0]      cnt;
  logic            run;
  logic [SQ_W-1:0] trial;

  assign trial = r + b;
  assign root  = r[ROOT_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'(ROOT_W - 1);
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // digit recurrence
  always_ff @(posedge clk) begin
    if (start) begin
      x <= radicand;
      r <= '0;
      b <= SQ_W'(1) << (2 * (ROOT_W - 1));
    end else if (run) begin
      if (x >= trial) begin
        x <= x - trial;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

// ===== rtl/svnb_div.sv =====
// restoring divider, one quotient bit per cycle, quotient known to fit
module svnb_div import svnb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [QUO_W-1:0]  quo,
  output logic              done
);

  logic [ROOT_W-1:0] rem;
  logic [QUO_W-1:0]  lo;
  logic [ROOT_W-1:0] dreg;
  logic [3:0]        cnt;
  logic              run;
  logic [ROOT_W:0]   t;
  logic              fits;

  assign t    = {rem, lo[QUO_W-1]};
  assign fits = t >= {1'b0, dreg};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 4'(QUO_W - 1);
      end else if (run) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= ROOT_W'(num[NUM_W-1:QUO_W]);
      lo   <= num[QUO_W-1:0];
      dreg <= den;
      quo  <= '0;
    end else if (run) begin
      rem <= fits ? ROOT_W'(t - {1'b0, dreg}) : t[ROOT_W-1:0];
      lo  <= lo << 1;
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/svnb_datapath.sv =====
// stores, multiplier, normalising and output registers of the normal builder
module svnb_datapath import svnb_pkg::*; #(
  parameter int MAX_VERTICES  = 64,
  parameter int POSITION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  svnb_cmd_t                 cmd,
  output svnb_stat_t                stat,
  input  logic signed [15:0]        pos_x,
  input  logic signed [15:0]        pos_y,
  input  logic signed [15:0]        pos_z,
  input  logic [CORNER_W-1:0]       corner_a,
  input  logic [CORNER_W-1:0]       corner_b,
  input  logic [CORNER_W-1:0]       corner_c,
  output logic [CORNER_W-1:0]       vertex_number,
  output logic signed [OUT_W-1:0]   normal_x,
  output logic signed [OUT_W-1:0]   normal_y,
  output logic signed [OUT_W-1:0]   normal_z
);

  localparam int P  = POSITION_BITS;
  localparam int EW = P + 1;
  localparam int MW = (EW > ROOT_W) ? EW : ROOT_W;
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [3*P-1:0]     pos_mem [MAX_VERTICES];
  logic [3*ACC_W-1:0] acc_mem [MAX_VERTICES];

  logic [CW-1:0] count;
  logic [IW-1:0] vidx;
  logic [IW-1:0] corner [3];

  logic [3*P-1:0]     pos_rdata;
  logic [3*ACC_W-1:0] acc_rdata;
  logic               pos_lat_v;
  logic [1:0]         pos_lat_sel;
  logic [3*P-1:0]     pv [3];

  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];

  logic signed [MW-1:0]   ma, mb;
  logic signed [2*MW-1:0] prod;
  logic                   mul_v_d, mul_sq_d;
  logic [2:0]             mul_sel_d;
  logic [ACC_W-1:0]       hold, cx, cy, cz;

  logic [ACC_W-1:0] mag [3];
  logic             neg [3];
  logic [ACC_W-1:0] m;
  logic [SQ_W-1:0]  sumsq;

  logic [ROOT_W-1:0] root;
  logic              sqrt_done;
  logic [QUO_W-1:0]  quo;
  logic              div_done;
  logic [1:0]        div_sel;
  logic [QUO_W-1:0]  q [3];
  logic [NUM_W-1:0]  num;

  logic [IW-1:0]      acc_raddr, acc_waddr;
  logic [3*ACC_W-1:0] acc_wdata;
  logic               acc_we, load_ok;
  logic [ACC_W-1:0]   av [3];
  logic [ACC_W-1:0]   mx01;
  logic [OUT_W-1:0]   nrm [3];

  // status
  assign load_ok = count < CW'(MAX_VERTICES);
  assign stat.tri_ok = ({1'b0, corner_a} < 7'(count)) && ({1'b0, corner_b} < 7'(count)) &&
                       ({1'b0, corner_c} < 7'(count));
  assign stat.store_empty = count == '0;
  assign stat.mag_zero    = m == '0;
  assign stat.norm_ok     = (m < (ACC_W'(1) << NORM_W)) && (m >= (ACC_W'(1) << (NORM_W - 1)));
  assign stat.sqrt_done   = sqrt_done;
  assign stat.div_done    = div_done;
  assign stat.last_vertex = CW'(vidx) == count - CW'(1);

  // store fill count and vertex walk
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load && load_ok) begin
      count <= count + CW'(1);
    end else if (cmd.next_vertex && stat.last_vertex) begin
      count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_init) begin
      vidx <= '0;
    end else if (cmd.next_vertex) begin
      vidx <= vidx + IW'(1);
    end
    if (cmd.tri_cap) begin
      corner[0] <= corner_a[IW-1:0];
      corner[1] <= corner_b[IW-1:0];
      corner[2] <= corner_c[IW-1:0];
    end
  end

  // position store
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      pos_mem[count[IW-1:0]] <= {P'(pos_x), P'(pos_y), P'(pos_z)};
    end
    if (cmd.pos_rd) begin
      pos_rdata <= pos_mem[corner[cmd.sel]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_lat_v <= 1'b0;
    end else begin
      pos_lat_v <= cmd.pos_rd;
    end
  end

  always_ff @(posedge clk) begin
    pos_lat_sel <= cmd.sel;
    if (pos_lat_v) begin
      pv[pos_lat_sel] <= pos_rdata;
    end
  end

  // accumulator store
  assign acc_raddr = cmd.use_vidx ? vidx : corner[cmd.sel];
  assign av[0] = acc_rdata[3*ACC_W-1:2*ACC_W];
  assign av[1] = acc_rdata[2*ACC_W-1:ACC_W];
  assign av[2] = acc_rdata[ACC_W-1:0];

  always_comb begin
    acc_we    = cmd.acc_wr || (cmd.load && load_ok);
    acc_waddr = cmd.acc_wr ? corner[cmd.sel] : count[IW-1:0];
    acc_wdata = cmd.acc_wr ? {av[0] + cx, av[1] + cy, av[2] + cz} : '0;
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (cmd.acc_rd) begin
      acc_rdata <= acc_mem[acc_raddr];
    end
  end

  // triangle edges
  always_ff @(posedge clk) begin
    if (cmd.edge_en) begin
      e1[0] <= EW'(signed'(pv[0][3*P-1:2*P])) - EW'(signed'(pv[1][3*P-1:2*P]));
      e1[1] <= EW'(signed'(pv[0][2*P-1:P]))   - EW'(signed'(pv[1][2*P-1:P]));
      e1[2] <= EW'(signed'(pv[0][P-1:0]))     - EW'(signed'(pv[1][P-1:0]));
      e2[0] <= EW'(signed'(pv[1][3*P-1:2*P])) - EW'(signed'(pv[2][3*P-1:2*P]));
      e2[1] <= EW'(signed'(pv[1][2*P-1:P]))   - EW'(signed'(pv[2][2*P-1:P]));
      e2[2] <= EW'(signed'(pv[1][P-1:0]))     - EW'(signed'(pv[2][P-1:0]));
    end
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd.mul_sq) begin
      case (cmd.mul_sel)
        3'd0: ma = MW'(signed'({1'b0, mag[0][NORM_W-1:0]}));
        3'd1: ma = MW'(signed'({1'b0, mag[1][NORM_W-1:0]}));
        3'd2: ma = MW'(signed'({1'b0, mag[2][NORM_W-1:0]}));
        default: ma = '0;
      endcase
      mb = ma;
    end else begin
      case (cmd.mul_sel)
        3'd0: begin ma = MW'(e1[1]); mb = MW'(e2[2]); end
        3'd1: begin ma = MW'(e1[2]); mb = MW'(e2[1]); end
        3'd2: begin ma = MW'(e1[2]); mb = MW'(e2[0]); end
        3'd3: begin ma = MW'(e1[0]); mb = MW'(e2[2]); end
        3'd4: begin ma = MW'(e1[0]); mb = MW'(e2[1]); end
        3'd5: begin ma = MW'(e1[1]); mb = MW'(e2[0]); end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v_d <= 1'b0;
    end else begin
      mul_v_d <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= ma * mb;
    mul_sq_d  <= cmd.mul_sq;
    mul_sel_d <= cmd.mul_sel;
  end

  // cross product and sum of squares from registered products
  always_ff @(posedge clk) begin
    if (cmd.sq_clr) begin
      sumsq <= '0;
    end else if (mul_v_d && mul_sq_d) begin
      sumsq <= sumsq + SQ_W'(prod[2*NORM_W-1:0]);
    end
    if (mul_v_d && !mul_sq_d) begin
      case (mul_sel_d)
        3'd1: cx <= hold - prod[ACC_W-1:0];
        3'd3: cy <= hold - prod[ACC_W-1:0];
        3'd5: cz <= hold - prod[ACC_W-1:0];
        default: hold <= prod[ACC_W-1:0];
      endcase
    end
  end

  // magnitudes, largest and power-of-two scaling
  assign mx01 = (mag[0] > mag[1]) ? mag[0] : mag[1];

  always_ff @(posedge clk) begin
    if (cmd.abs_en) begin
      for (int i = 0; i < 3; i++) begin
        neg[i] <= av[i][ACC_W-1];
        mag[i] <= av[i][ACC_W-1] ? (~av[i] + ACC_W'(1)) : av[i];
      end
    end else if (cmd.norm_step) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= (m >= (ACC_W'(1) << NORM_W)) ? (mag[i] >> 1) : (mag[i] << 1);
      end
    end
    if (cmd.max_en) begin
      m <= (mx01 > mag[2]) ? mx01 : mag[2];
    end else if (cmd.norm_step) begin
      m <= (m >= (ACC_W'(1) << NORM_W)) ? (m >> 1) : (m << 1);
    end
  end

  // length and per-component quotients
  svnb_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (sumsq),
    .root     (root),
    .done     (sqrt_done)
  );

  assign num = NUM_W'({mag[cmd.sel][NORM_W-1:0], 14'b0}) + NUM_W'(root[ROOT_W-1:1]);

  svnb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (root),
    .quo   (quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel <= cmd.sel;
    end
    if (div_done) begin
      q[div_sel] <= quo;
    end
  end

  // result fields
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = stat.mag_zero ? '0 : (neg[i] ? -OUT_W'(q[i]) : OUT_W'(q[i]));
    end
  end

  assign vertex_number = CORNER_W'(vidx);
  assign normal_x = nrm[0];
  assign normal_y = nrm[1];
  assign normal_z = nrm[2];

endmodule

// ===== rtl/svnb_ctrl.sv =====
// controller state machine of the normal builder
module svnb_ctrl import svnb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] func,
  input  svnb_stat_t stat,
  output svnb_cmd_t  cmd,
  output logic       busy,
  output logic       strobe
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_TRD   = 5'd1;
  localparam logic [4:0] S_TWAIT = 5'd2;
  localparam logic [4:0] S_TEDGE = 5'd3;
  localparam logic [4:0] S_TMUL  = 5'd4;
  localparam logic [4:0] S_TACR  = 5'd5;
  localparam logic [4:0] S_TACW  = 5'd6;
  localparam logic [4:0] S_FRD   = 5'd7;
  localparam logic [4:0] S_FABS  = 5'd8;
  localparam logic [4:0] S_FMAX  = 5'd9;
  localparam logic [4:0] S_FNORM = 5'd10;
  localparam logic [4:0] S_FSQ   = 5'd11;
  localparam logic [4:0] S_FSQE  = 5'd12;
  localparam logic [4:0] S_FSQS  = 5'd13;
  localparam logic [4:0] S_FSQW  = 5'd14;
  localparam logic [4:0] S_FDIV  = 5'd15;
  localparam logic [4:0] S_FDIVW = 5'd16;
  localparam logic [4:0] S_FEMIT = 5'd17;

  logic [4:0] state, state_next;
  logic [2:0] step, step_next;

  assign busy   = state != S_IDLE;
  assign strobe = state == S_FEMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    cmd.sel    = step[1:0];
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        step_next = '0;
        if (start) begin
          case (func)
            FUNC_LOAD: cmd.load = 1'b1;
            FUNC_TRI: begin
              cmd.tri_cap = 1'b1;
              if (stat.tri_ok) state_next = S_TRD;
            end
            FUNC_FIN: begin
              cmd.fin_init = 1'b1;
              if (!stat.store_empty) state_next = S_FRD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_TRD: begin
        cmd.pos_rd = 1'b1;
        if (step == 3'd2) begin
          state_next = S_TWAIT;
          step_next  = '0;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_TWAIT: state_next = S_TEDGE;
      S_TEDGE: begin
        cmd.edge_en = 1'b1;
        state_next  = S_TMUL;
      end
      S_TMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = step;
        if (step == 3'd5) begin
          state_next = S_TACR;
          step_next  = '0;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_TACR: begin
        cmd.acc_rd = 1'b1;
        state_next = S_TACW;
      end
      S_TACW: begin
        cmd.acc_wr = 1'b1;
        if (step == 3'd2) begin
          state_next = S_IDLE;
        end else begin
          step_next  = step + 3'd1;
          state_next = S_TACR;
        end
      end
      S_FRD: begin
        cmd.acc_rd   = 1'b1;
        cmd.use_vidx = 1'b1;
        state_next   = S_FABS;
      end
      S_FABS: begin
        cmd.abs_en = 1'b1;
        state_next = S_FMAX;
      end
      S_FMAX: begin
        cmd.max_en = 1'b1;
        state_next = S_FNORM;
      end
      S_FNORM: begin
        step_next = '0;
        if (stat.mag_zero) begin
          state_next = S_FEMIT;
        end else if (stat.norm_ok) begin
          state_next = S_FSQ;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_FSQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sq  = 1'b1;
        cmd.mul_sel = step;
        cmd.sq_clr  = step == 3'd0;
        if (step == 3'd2) begin
          state_next = S_FSQE;
          step_next  = '0;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_FSQE: state_next = S_FSQS;
      S_FSQS: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_FSQW;
      end
      S_FSQW: begin
        if (stat.sqrt_done) state_next = S_FDIV;
      end
      S_FDIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_FDIVW;
      end
      S_FDIVW: begin
        if (stat.div_done) begin
          if (step == 3'd2) begin
            state_next = S_FEMIT;
          end else begin
            step_next  = step + 3'd1;
            state_next = S_FDIV;
          end
        end
      end
      S_FEMIT: begin
        cmd.next_vertex = 1'b1;
        state_next      = stat.last_vertex ? S_IDLE : S_FRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/smooth_vertex_normal_builder.sv =====
// Smooth vertex normal builder, top level. An item is taken when start is high and busy is
// low. A load item takes effect at once and leaves busy low. A triangle item with loaded
// corners holds busy through three position reads, a wait and an edge step, six products on
// the one shared multiplier and three accumulator read-modify-writes, each a read state and
// a write state. A finish item walks the loaded vertices one at a time. A vertex whose sum
// is zero is read, ranged and emitted. Any other vertex is read and ranged, scaled in up to
// 29 one-bit steps, then passes through squares, a square root (one bit a cycle), three
// divisions and the emit state. Each normal appears for one cycle with strobe high and cannot
// be held off; last marks the final one, after which the store is empty and busy drops.
module smooth_vertex_normal_builder import svnb_pkg::*; #(
  parameter int MAX_VERTICES  = 64,
  parameter int POSITION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              func,
  input  logic signed [15:0]      pos_x,
  input  logic signed [15:0]      pos_y,
  input  logic signed [15:0]      pos_z,
  input  logic [CORNER_W-1:0]     corner_a,
  input  logic [CORNER_W-1:0]     corner_b,
  input  logic [CORNER_W-1:0]     corner_c,
  output logic                    strobe,
  output logic [CORNER_W-1:0]     vertex_number,
  output logic signed [OUT_W-1:0] normal_x,
  output logic signed [OUT_W-1:0] normal_y,
  output logic signed [OUT_W-1:0] normal_z,
  output logic                    last
);

`include "smooth_vertex_normal_builder_assert.svh"

  svnb_cmd_t  cmd;
  svnb_stat_t stat;

  // sequencing
  svnb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  // storage and arithmetic
  svnb_datapath #(
    .MAX_VERTICES  (MAX_VERTICES),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .corner_a      (corner_a),
    .corner_b      (corner_b),
    .corner_c      (corner_c),
    .vertex_number (vertex_number),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z)
  );

  assign last = strobe && stat.last_vertex;

  // a result only appears inside a finish run
  `SVNB_ASSERT_NOW(a_strobe_busy, clk, rst, strobe, busy)
  // the final result ends the run
  `SVNB_ASSERT_NEXT(a_last_ends, clk, rst, strobe && last, !busy && !strobe)
  // results never come back to back: each vertex needs its own arithmetic
  `SVNB_ASSERT_NEXT(a_strobe_gap, clk, rst, strobe && !last, busy && !strobe)

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the smooth vertex normal builder
`timescale 1ns / 100ps

module testbench;
  import svnb_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int CAPACITY = 64;
  localparam int IDLE_LIMIT = 40000;
  localparam logic [47:0] ACC_MASK = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [5:0]  vnum;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        fin;
  } normal_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  func;
  logic signed [15:0] pos_x, pos_y, pos_z;
  logic [5:0]  corner_a, corner_b, corner_c;
  logic        strobe;
  logic [5:0]  vertex_number;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic        last;

  // predictor state
  logic signed [15:0] vert_pos [CAPACITY][3];
  logic [47:0]        vert_sum [CAPACITY][3];
  int                 vert_count;

  normal_t normal_queue[$];
  int      mismatch_count;
  int      progress_count;
  int      burst_left;

  smooth_vertex_normal_builder u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .strobe(strobe), .vertex_number(vertex_number),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z), .last(last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // scale a 48-bit sum vector to a q1.14 unit normal
  function automatic void unit_normal(input logic [47:0] s [3], output logic [15:0] n [3]);
    longint unsigned mag [3];
    logic            neg [3];
    longint unsigned peak, len, q;
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = s[i][47];
      mag[i] = neg[i] ? longint'((-s[i]) & ACC_MASK) : longint'(s[i]);
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) begin
      for (int i = 0; i < 3; i++) n[i] = '0;
      return;
    end
    while (peak >= (64'd1 << 30)) begin
      peak = peak >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (peak < (64'd1 << 29)) begin
      peak = peak << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 64'd16384 + (len >> 1)) / len;
      n[i] = neg[i] ? 16'(-q) : 16'(q);
    end
  endfunction

  // update the mesh state for one accepted item and queue any normals
  task automatic predict_mesh(input logic [1:0] f, input logic signed [15:0] x, y, z,
                              input logic [5:0] a, b, c);
    longint    e1 [3];
    longint    e2 [3];
    longint    cr [3];
    int        cn [3];
    logic [15:0] nv [3];
    normal_t   item;
    case (f)
      FUNC_LOAD: begin
        if (vert_count < CAPACITY) begin
          vert_pos[vert_count][0] = x;
          vert_pos[vert_count][1] = y;
          vert_pos[vert_count][2] = z;
          for (int i = 0; i < 3; i++) vert_sum[vert_count][i] = '0;
          vert_count++;
        end
      end
      FUNC_TRI: begin
        cn[0] = int'(a); cn[1] = int'(b); cn[2] = int'(c);
        if (cn[0] < vert_count && cn[1] < vert_count && cn[2] < vert_count) begin
          for (int i = 0; i < 3; i++) begin
            e1[i] = longint'(vert_pos[cn[0]][i]) - longint'(vert_pos[cn[1]][i]);
            e2[i] = longint'(vert_pos[cn[1]][i]) - longint'(vert_pos[cn[2]][i]);
          end
          cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
          cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
          cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
          for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
              vert_sum[cn[k]][i] = vert_sum[cn[k]][i] + 48'(cr[i]);
        end
      end
      FUNC_FIN: begin
        for (int v = 0; v < vert_count; v++) begin
          unit_normal(vert_sum[v], nv);
          item.vnum = 6'(v);
          item.nx = nv[0];
          item.ny = nv[1];
          item.nz = nv[2];
          item.fin = (v + 1 == vert_count);
          normal_queue.push_back(item);
        end
        vert_count = 0;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got, want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // send one item, wait for it to be taken, then maybe pause
  task automatic send_item(input logic [1:0] f, input logic signed [15:0] x, y, z,
                           input logic [5:0] a, b, c);
    func <= f; pos_x <= x; pos_y <= y; pos_z <= z;
    corner_a <= a; corner_b <= b; corner_c <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    progress_count++;
    predict_mesh(f, x, y, z, a, b, c);
    if (burst_left == 0) begin
      start <= 1'b0;
      burst_left = $urandom_range(0, 9);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_vertex(input logic signed [15:0] x, y, z);
    send_item(FUNC_LOAD, x, y, z, 6'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic add_triangle(input logic [5:0] a, b, c);
    send_item(FUNC_TRI, 16'($urandom), 16'($urandom), 16'($urandom), a, b, c);
  endtask

  task automatic finish_mesh();
    send_item(FUNC_FIN, 16'($urandom), 16'($urandom), 16'($urandom),
              6'($urandom), 6'($urandom), 6'($urandom));
  endtask

  // extremes, repeated and unloaded corners, zero normals, spare code, empty finish
  task automatic test_directed();
    finish_mesh();
    load_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    load_vertex(16'sh8000, 16'sh7FFF, 16'sh8000);
    load_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000);
    load_vertex(16'sh0000, 16'sh0000, 16'sh0000);
    load_vertex(16'sh0100, 16'sh0000, 16'sh0000);
    add_triangle(6'd0, 6'd1, 6'd2);
    add_triangle(6'd2, 6'd1, 6'd0);
    add_triangle(6'd1, 6'd1, 6'd1);
    add_triangle(6'd0, 6'd0, 6'd4);
    add_triangle(6'd0, 6'd3, 6'd4);
    add_triangle(6'd5, 6'd0, 6'd1);
    add_triangle(6'd0, 6'd63, 6'd1);
    send_item(FUNC_SPARE, 16'shFFFF, 16'shFFFF, 16'shFFFF, 6'h3F, 6'h3F, 6'h3F);
    add_triangle(6'd3, 6'd4, 6'd0);
    finish_mesh();
    finish_mesh();
  endtask

  // fill past capacity so surplus loads are dropped and index 63 is used
  task automatic test_store_full();
    for (int i = 0; i < CAPACITY + 3; i++)
      load_vertex(16'($urandom_range(0, 4095) - 2048), 16'($urandom_range(0, 4095) - 2048),
                  16'($urandom_range(0, 4095) - 2048));
    add_triangle(6'd63, 6'd0, 6'd31);
    add_triangle(6'd62, 6'd63, 6'd1);
    add_triangle(6'd42, 6'd21, 6'd63);
    finish_mesh();
  endtask

  // random small meshes, mostly well formed
  task automatic test_random_meshes();
    int sent;
    int n;
    int tris;
    sent = 0;
    while (sent < 190) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(3, 10);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1))
          load_vertex(16'($urandom), 16'($urandom), 16'($urandom));
        else
          load_vertex(16'($urandom_range(0, 2047) - 1024),
                      16'($urandom_range(0, 2047) - 1024),
                      16'($urandom_range(0, 2047) - 1024));
      end
      tris = $urandom_range(1, 2 * n);
      for (int t = 0; t < tris; t++) begin
        if ($urandom_range(0, 9) == 0)
          add_triangle(6'($urandom), 6'($urandom), 6'($urandom));
        else
          add_triangle(6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)),
                       6'($urandom_range(0, n - 1)));
      end
      if ($urandom_range(0, 7) == 0)
        send_item(FUNC_SPARE, 16'($urandom), 16'($urandom), 16'($urandom),
                  6'($urandom), 6'($urandom), 6'($urandom));
      finish_mesh();
      sent += n + tris + 1;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    normal_t want;
    if (!rst && strobe) begin
      progress_count++;
      if (normal_queue.size() == 0) begin
        report_mismatch("unexpected normal, vertex", 16'(vertex_number), 16'h0);
      end else begin
        want = normal_queue.pop_front();
        if (vertex_number !== want.vnum)
          report_mismatch("vertex_number", 16'(vertex_number), 16'(want.vnum));
        if (normal_x !== want.nx) report_mismatch("normal_x", normal_x, want.nx);
        if (normal_y !== want.ny) report_mismatch("normal_y", normal_y, want.ny);
        if (normal_z !== want.nz) report_mismatch("normal_z", normal_z, want.nz);
        if (last !== want.fin) report_mismatch("last", 16'(last), 16'(want.fin));
      end
    end
  end

  // watchdog on cycles without progress
  initial begin
    int idle;
    int seen;
    idle = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (progress_count != seen) begin
        seen = progress_count;
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    mismatch_count = 0;
    progress_count = 0;
    burst_left = 0;
    vert_count = 0;
    rst <= 1'b1;
    start <= 1'b0;
    func <= FUNC_LOAD;
    pos_x <= '0; pos_y <= '0; pos_z <= '0;
    corner_a <= '0; corner_b <= '0; corner_c <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_random_meshes();
    start <= 1'b0;
    while (normal_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/svnb_pkg.sv
rtl/svnb_isqrt.sv
rtl/svnb_div.sv
rtl/svnb_datapath.sv
rtl/svnb_ctrl.sv
rtl/smooth_vertex_normal_builder.sv
dv/testbench.sv
